>>> design/le3d_pkg.sv
// Shared types, register codes and constants of the six-neighbour extremum detector.
package le3d_pkg;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int SAMPLE_W  = 32;
  localparam int IDX_W     = 24;
  localparam int CNT_W     = 25;

  localparam int DEF_MAX_SIZE_X = 256;
  localparam int DEF_MAX_SIZE_Y = 256;
  localparam int DEF_MAX_SIZE_Z = 256;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 9'd256;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  typedef struct packed {
    logic                       req_type;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] voxel_index;
    logic             is_extremum;
    logic             is_maximum;
    logic [CNT_W-1:0] extrema_so_far;
    logic             last_voxel;
  } out_item_t;

endpackage

>>> design/le3d_ram.sv
// Sample window RAM: one write port, two registered read ports.
module le3d_ram #(
  parameter int AW = 17,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [0:(1<<AW)-1];
  logic [DW-1:0] rdata_a_r;
  logic [DW-1:0] rdata_b_r;

  // read returns the old word when the same entry is written in that cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

>>> design/local_extrema_3d_six_neighbour_unit.sv
// Top level of the streaming six-neighbour local extremum detector.
//
// Accepts one transaction per cycle while in_ready is high, samples in x,
// then y, then z order, and returns one result per voxel, one plane behind the
// input; the results of the final plane are drained by flush transactions, one
// per flush. A result passes the stage 1 registers and the result queue before
// it is presented. The window of two planes is held in two identical RAM
// copies, each with one write and two read ports, so that the four window
// neighbours not covered by the running x registers are read together; the
// incoming sample serves as the plus-z neighbour. The window needs no clearing
// after reset: an entry is read only after it was written in the current
// volume. A write to a size register restarts the stream.
module local_extrema_3d_six_neighbour_unit #(
  parameter int MAX_SIZE_X = le3d_pkg::DEF_MAX_SIZE_X,
  parameter int MAX_SIZE_Y = le3d_pkg::DEF_MAX_SIZE_Y,
  parameter int MAX_SIZE_Z = le3d_pkg::DEF_MAX_SIZE_Z
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  le3d_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output le3d_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [le3d_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [le3d_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int XW = (MAX_SIZE_X > 1) ? $clog2(MAX_SIZE_X) : 1;
  localparam int YW = (MAX_SIZE_Y > 1) ? $clog2(MAX_SIZE_Y) : 1;
  localparam int ZW = (MAX_SIZE_Z > 1) ? $clog2(MAX_SIZE_Z) : 1;
  localparam int AW = 1 + YW + XW;
  localparam int SW = le3d_pkg::SAMPLE_W;

  typedef enum logic [1:0] {
    CTR_CHAIN,
    CTR_MEM1A,
    CTR_MEM1B
  } ctr_sel_t;

  typedef struct packed {
    logic                       has_xm;
    logic                       has_xp;
    logic                       has_ym;
    logic                       has_yp;
    logic                       has_zm;
    logic                       has_zp;
    ctr_sel_t                   ctr_sel;
    logic [le3d_pkg::IDX_W-1:0] voxel_index;
    logic                       last;
  } s1_ctrl_t;

  // size register value to effective size minus one
  function automatic int size_m1(input logic [le3d_pkg::CFG_W-1:0] v, input int maxv);
    int r;
    if (v == '0) begin
      r = 0;
    end else if (int'(v) > maxv) begin
      r = maxv - 1;
    end else begin
      r = int'(v) - 1;
    end
    return r;
  endfunction

  // configuration
  logic [XW-1:0] sx_m1_r;
  logic [YW-1:0] sy_m1_r;
  logic [ZW-1:0] sz_m1_r;
  logic          cfg_restart;

  // positions
  logic [XW-1:0] in_x_r, in_x_nxt;
  logic [YW-1:0] in_y_r, in_y_nxt;
  logic [ZW-1:0] in_z_r, in_z_nxt;
  logic          in_full_r, in_full_nxt;
  logic [XW-1:0] out_x_r, out_x_nxt;
  logic [YW-1:0] out_y_r, out_y_nxt;
  logic [ZW-1:0] out_z_r, out_z_nxt;
  logic [le3d_pkg::IDX_W-1:0] out_pos_r, out_pos_nxt;

  // stage 0 decode
  logic          is_flush, accept, do_write, do_proc;
  logic          in_x_wrap, in_y_wrap, in_z_wrap;
  logic          out_x_wrap, out_y_wrap, out_z_wrap, out_last;
  logic [XW-1:0] nx;
  logic [YW-1:0] ny, out_y_inc, out_y_dec;
  logic [ZW-1:0] nz;
  logic          at_origin, plane_one;
  logic [AW-1:0] waddr, a1a, a1b, a2a, a2b;
  s1_ctrl_t      s1_ctrl_nxt;

  // stage 1
  logic                 s1_valid_r;
  s1_ctrl_t             s1_ctrl_r;
  logic signed [SW-1:0] s1_sample_r;
  logic signed [SW-1:0] m1a_rd, m1b_rd, m2a_rd, m2b_rd;
  logic signed [SW-1:0] center;
  logic signed [SW-1:0] chain_center_r, chain_next_r;
  logic                 no_greater, no_smaller, ext;
  logic [le3d_pkg::CNT_W-1:0] count_r, count_inc;
  le3d_pkg::out_item_t  s1_item;

  // result queue
  le3d_pkg::out_item_t fifo_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fifo_cnt_r;
  logic       push, pop;
  logic [2:0] occ;

  assign cfg_restart = cfg_we && (cfg_index == le3d_pkg::REG_SIZE_X ||
                                  cfg_index == le3d_pkg::REG_SIZE_Y ||
                                  cfg_index == le3d_pkg::REG_SIZE_Z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_m1_r <= XW'(size_m1(le3d_pkg::CFG_SIZE_RESET, MAX_SIZE_X));
      sy_m1_r <= YW'(size_m1(le3d_pkg::CFG_SIZE_RESET, MAX_SIZE_Y));
      sz_m1_r <= ZW'(size_m1(le3d_pkg::CFG_SIZE_RESET, MAX_SIZE_Z));
    end else if (cfg_we) begin
      case (cfg_index)
        le3d_pkg::REG_SIZE_X: sx_m1_r <= XW'(size_m1(cfg_wdata, MAX_SIZE_X));
        le3d_pkg::REG_SIZE_Y: sy_m1_r <= YW'(size_m1(cfg_wdata, MAX_SIZE_Y));
        le3d_pkg::REG_SIZE_Z: sz_m1_r <= ZW'(size_m1(cfg_wdata, MAX_SIZE_Z));
        default: ;
      endcase
    end
  end

  // handshake: keep room for every result still in flight
  assign pop       = out_valid && out_ready;
  assign occ       = {1'b0, fifo_cnt_r} + {2'b00, s1_valid_r};
  assign in_ready  = occ < (3'd2 + {2'b00, pop});
  assign out_valid = fifo_cnt_r != 2'd0;
  assign out_data  = fifo_r[rd_ptr_r];

  always_comb begin
    is_flush = in_data.req_type == le3d_pkg::REQ_FLUSH;
    accept   = in_valid && in_ready;
    do_write = accept && !is_flush && !in_full_r;
    do_proc  = accept && (is_flush ? in_full_r : (!in_full_r && in_z_r != '0));

    in_x_wrap  = in_x_r == sx_m1_r;
    in_y_wrap  = in_y_r == sy_m1_r;
    in_z_wrap  = in_z_r == sz_m1_r;
    out_x_wrap = out_x_r == sx_m1_r;
    out_y_wrap = out_y_r == sy_m1_r;
    out_z_wrap = out_z_r == sz_m1_r;
    out_last   = out_x_wrap && out_y_wrap && out_z_wrap;

    out_y_inc = out_y_r + YW'(1);
    out_y_dec = out_y_r - YW'(1);
    nx = out_x_wrap ? '0 : out_x_r + XW'(1);
    ny = out_x_wrap ? (out_y_wrap ? '0 : out_y_inc) : out_y_r;
    nz = (out_x_wrap && out_y_wrap) ? (out_z_wrap ? '0 : out_z_r + ZW'(1)) : out_z_r;

    at_origin = out_x_r == '0 && out_y_r == '0 && out_z_r == '0;
    plane_one = sx_m1_r == '0 && sy_m1_r == '0;

    // window slot is z parity, row, column
    waddr = {in_z_r[0], in_y_r, in_x_r};
    a1a   = at_origin ? {out_z_r[0], out_y_r, out_x_r} : {~out_z_r[0], out_y_r, out_x_r};
    a1b   = plane_one ? {out_z_r[0], out_y_r, out_x_r} : {out_z_r[0], out_y_inc, out_x_r};
    a2a   = {out_z_r[0], out_y_dec, out_x_r};
    a2b   = {nz[0], ny, nx};

    s1_ctrl_nxt.has_xm      = out_x_r != '0;
    s1_ctrl_nxt.has_xp      = !out_x_wrap;
    s1_ctrl_nxt.has_ym      = out_y_r != '0;
    s1_ctrl_nxt.has_yp      = !out_y_wrap;
    s1_ctrl_nxt.has_zm      = out_z_r != '0;
    s1_ctrl_nxt.has_zp      = !out_z_wrap;
    s1_ctrl_nxt.ctr_sel     = at_origin ? CTR_MEM1A : (plane_one ? CTR_MEM1B : CTR_CHAIN);
    s1_ctrl_nxt.voxel_index = out_pos_r;
    s1_ctrl_nxt.last        = out_last;

    in_x_nxt    = in_x_r;
    in_y_nxt    = in_y_r;
    in_z_nxt    = in_z_r;
    in_full_nxt = in_full_r;
    out_x_nxt   = out_x_r;
    out_y_nxt   = out_y_r;
    out_z_nxt   = out_z_r;
    out_pos_nxt = out_pos_r;

    if (do_write) begin
      if (in_x_wrap && in_y_wrap && in_z_wrap) begin
        in_full_nxt = 1'b1;
        in_x_nxt    = '0;
        in_y_nxt    = '0;
        in_z_nxt    = '0;
      end else begin
        in_x_nxt = in_x_wrap ? '0 : in_x_r + XW'(1);
        in_y_nxt = in_x_wrap ? (in_y_wrap ? '0 : in_y_r + YW'(1)) : in_y_r;
        in_z_nxt = (in_x_wrap && in_y_wrap) ? in_z_r + ZW'(1) : in_z_r;
      end
    end

    if (do_proc) begin
      out_x_nxt   = nx;
      out_y_nxt   = ny;
      out_z_nxt   = nz;
      out_pos_nxt = out_pos_r + le3d_pkg::IDX_W'(1);
      // end of volume: start over
      if (out_last) begin
        in_full_nxt = 1'b0;
        in_x_nxt    = '0;
        in_y_nxt    = '0;
        in_z_nxt    = '0;
        out_pos_nxt = '0;
      end
    end

    if (cfg_restart) begin
      in_full_nxt = 1'b0;
      in_x_nxt    = '0;
      in_y_nxt    = '0;
      in_z_nxt    = '0;
      out_x_nxt   = '0;
      out_y_nxt   = '0;
      out_z_nxt   = '0;
      out_pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_x_r     <= '0;
      in_y_r     <= '0;
      in_z_r     <= '0;
      in_full_r  <= 1'b0;
      out_x_r    <= '0;
      out_y_r    <= '0;
      out_z_r    <= '0;
      out_pos_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      in_x_r     <= in_x_nxt;
      in_y_r     <= in_y_nxt;
      in_z_r     <= in_z_nxt;
      in_full_r  <= in_full_nxt;
      out_x_r    <= out_x_nxt;
      out_y_r    <= out_y_nxt;
      out_z_r    <= out_z_nxt;
      out_pos_r  <= out_pos_nxt;
      s1_valid_r <= do_proc;
    end
  end

  always_ff @(posedge clk) begin
    if (do_proc) begin
      s1_ctrl_r   <= s1_ctrl_nxt;
      s1_sample_r <= in_data.sample;
    end
  end

  le3d_ram #(.AW(AW), .DW(SW)) u_ram_0 (
    .clk     (clk),
    .we      (do_write),
    .waddr   (waddr),
    .wdata   (in_data.sample),
    .raddr_a (a1a),
    .raddr_b (a1b),
    .rdata_a (m1a_rd),
    .rdata_b (m1b_rd)
  );

  le3d_ram #(.AW(AW), .DW(SW)) u_ram_1 (
    .clk     (clk),
    .we      (do_write),
    .waddr   (waddr),
    .wdata   (in_data.sample),
    .raddr_a (a2a),
    .raddr_b (a2b),
    .rdata_a (m2a_rd),
    .rdata_b (m2b_rd)
  );

  // stage 1: center and minus-x come from the running x registers unless the
  // voxel opens the volume or the plane is a single voxel
  always_comb begin
    case (s1_ctrl_r.ctr_sel)
      CTR_MEM1A: center = m1a_rd;
      CTR_MEM1B: center = m1b_rd;
      default:   center = chain_next_r;
    endcase

    no_greater = !((s1_ctrl_r.has_xm && chain_center_r > center) ||
                   (s1_ctrl_r.has_xp && m2b_rd > center) ||
                   (s1_ctrl_r.has_ym && m2a_rd > center) ||
                   (s1_ctrl_r.has_yp && m1b_rd > center) ||
                   (s1_ctrl_r.has_zm && m1a_rd > center) ||
                   (s1_ctrl_r.has_zp && s1_sample_r > center));
    no_smaller = !((s1_ctrl_r.has_xm && chain_center_r < center) ||
                   (s1_ctrl_r.has_xp && m2b_rd < center) ||
                   (s1_ctrl_r.has_ym && m2a_rd < center) ||
                   (s1_ctrl_r.has_yp && m1b_rd < center) ||
                   (s1_ctrl_r.has_zm && m1a_rd < center) ||
                   (s1_ctrl_r.has_zp && s1_sample_r < center));
    ext        = no_greater != no_smaller;
    count_inc  = count_r + {{(le3d_pkg::CNT_W-1){1'b0}}, ext};

    s1_item.voxel_index    = s1_ctrl_r.voxel_index;
    s1_item.is_extremum    = ext;
    s1_item.is_maximum     = ext && no_greater;
    s1_item.extrema_so_far = count_inc;
    s1_item.last_voxel     = s1_ctrl_r.last;
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      chain_center_r <= center;
      chain_next_r   <= m2b_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_restart) begin
      count_r <= '0;
    end else if (s1_valid_r) begin
      count_r <= s1_ctrl_r.last ? '0 : count_inc;
    end
  end

  // two-entry result queue
  assign push = s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
      fifo_cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      fifo_cnt_r <= fifo_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= s1_item;
    end
  end

endmodule
